[sv/tmhq_pkg.sv]
// package: sizes, codes, payload types and controller states of the timer heap queue
`default_nettype none
package tmhq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 64;
  localparam int ID_SLOTS    = 64;
  localparam int ID_W        = 6;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_POP    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_NONE    = 2'd2
  } kind_code_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOTQ    = 2'd2,
    STAT_ALREADY = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  timer_id;
    logic [63:0] expiry_time;
    logic [63:0] now_time;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] expired_id;
    logic [1:0] status;
    logic [6:0] queued_count;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] exp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAN_POS,
    ST_REM,
    ST_REM_LD,
    ST_UP_A,
    ST_UP_B,
    ST_DN_L,
    ST_DN_LW,
    ST_DN_R,
    ST_FIN,
    ST_POP_RD,
    ST_POP_CHK
  } state_t;

endpackage
`default_nettype wire

[sv/tmhq_ram.sv]
// simple dual-port ram: one write port, one registered read port
`default_nettype none
module tmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/timer_min_heap_queue.sv]
// top level: binary min-heap timer queue with id-to-slot map
// Timers are held in a binary min-heap ordered by expiry, stored in a one-port-read ram
// (id and expiry per slot); a second ram maps each timer id to its heap slot, and a
// flip-flop bit per id says whether that id is queued, so reset and clear take effect at
// once with no clearing pass. One command is worked on at a time. Push, cancel and pop
// run a sift through the heap ram, each level an issued read and then a compare and
// write back; a sift down reads the left and then the right child before its compare.
// Errors and clear go straight to the finish state and answer from there. Pop expired
// removes roots while their expiry is at most now, one transfer per expired id, the
// final one carrying last; when nothing is due one kind-none transfer is given. A
// finished result sits in an output register, so the next command is taken while it
// waits; the sequencer stalls only when it must hand over a second result.
`default_nettype none
module timer_min_heap_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output      logic                  cmd_ready,
  input  wire tmhq_pkg::cmd_item_t   cmd_item,
  output      logic                  res_valid,
  input  wire logic                  res_ready,
  output      tmhq_pkg::res_item_t   res_item
);
  import tmhq_pkg::*;

  localparam int XW = IDX_W + 2;

  // controller registers
  state_t               state, state_next;
  logic [IDX_W-1:0]     idx, idx_next;
  entry_t               cur, cur_next;
  entry_t               lchild, lchild_next;
  logic                 downf, downf_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [ID_SLOTS-1:0]  qvalid, qvalid_next;
  logic [1:0]           op, op_next;
  logic [1:0]           status, status_next;
  logic [ID_W-1:0]      gone, gone_next;
  logic [TIME_BITS-1:0] now_r, now_next;
  logic                 pend_v, pend_v_next;
  logic [ID_W-1:0]      pend_id, pend_id_next;

  // ram ports
  logic             hw_en;
  logic [IDX_W-1:0] hw_addr, h_raddr;
  entry_t           hw_data, h_rdata;
  logic             pw_en;
  logic [ID_W-1:0]  pw_addr, p_raddr;
  logic [IDX_W-1:0] pw_data, p_rdata;

  // result register
  logic      emit;
  res_item_t emit_data;
  logic      slot_free;

  // child and parent indexes
  logic [XW-1:0]    lidx, ridx, cnt_x;
  logic [IDX_W-1:0] pidx;
  logic             take_l, take_r;

  assign slot_free = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE);
  assign lidx      = {1'b0, idx, 1'b1};
  assign ridx      = {1'b0, idx, 1'b0} + XW'(2);
  assign cnt_x     = XW'(count);
  assign pidx      = IDX_W'((idx - 1'b1) >> 1);

  // sift down choice: left only when strictly smaller, right only when smaller still
  assign take_l = lchild.exp < cur.exp;
  assign take_r = (ridx < cnt_x) &&
                  (h_rdata.exp < (take_l ? lchild.exp : cur.exp));

  tmhq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk   (clk),
    .we    (hw_en),
    .waddr (hw_addr),
    .wdata (hw_data),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  tmhq_ram #(.WIDTH(IDX_W), .DEPTH(ID_SLOTS)) u_pos (
    .clk   (clk),
    .we    (pw_en),
    .waddr (pw_addr),
    .wdata (pw_data),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      qvalid    <= '0;
      pend_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      qvalid <= qvalid_next;
      pend_v <= pend_v_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    idx     <= idx_next;
    cur     <= cur_next;
    lchild  <= lchild_next;
    downf   <= downf_next;
    op      <= op_next;
    status  <= status_next;
    gone    <= gone_next;
    now_r   <= now_next;
    pend_id <= pend_id_next;
    if (emit) begin
      res_item <= emit_data;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cur_next     = cur;
    lchild_next  = lchild;
    downf_next   = downf;
    count_next   = count;
    qvalid_next  = qvalid;
    op_next      = op;
    status_next  = status;
    gone_next    = gone;
    now_next     = now_r;
    pend_v_next  = pend_v;
    pend_id_next = pend_id;
    hw_en        = 1'b0;
    hw_addr      = idx;
    hw_data      = cur;
    h_raddr      = '0;
    pw_en        = 1'b0;
    pw_addr      = cur.id;
    pw_data      = idx;
    p_raddr      = cmd_item.timer_id;
    emit         = 1'b0;
    emit_data    = '0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          op_next     = cmd_item.cmd;
          now_next    = cmd_item.now_time[TIME_BITS-1:0];
          status_next = STAT_OK;
          case (cmd_item.cmd)
            CMD_PUSH: begin
              if (qvalid[cmd_item.timer_id]) begin
                status_next = STAT_ALREADY;
                state_next  = ST_FIN;
              end else if (count >= CNT_W'(QUEUE_DEPTH)) begin
                status_next = STAT_FULL;
                state_next  = ST_FIN;
              end else begin
                cur_next.id  = cmd_item.timer_id;
                cur_next.exp = cmd_item.expiry_time[TIME_BITS-1:0];
                idx_next     = IDX_W'(count);
                count_next   = count + 1'b1;
                qvalid_next[cmd_item.timer_id] = 1'b1;
                downf_next   = 1'b0;
                state_next   = ST_UP_A;
              end
            end
            CMD_CANCEL: begin
              if (!qvalid[cmd_item.timer_id]) begin
                status_next = STAT_NOTQ;
                state_next  = ST_FIN;
              end else begin
                // slot of this id arrives from the position ram next cycle
                gone_next  = cmd_item.timer_id;
                state_next = ST_CAN_POS;
              end
            end
            CMD_CLEAR: begin
              qvalid_next = '0;
              count_next  = '0;
              state_next  = ST_FIN;
            end
            default: begin
              // pop expired: root read issued now
              pend_v_next = 1'b0;
              state_next  = ST_POP_CHK;
            end
          endcase
        end
      end

      ST_CAN_POS: begin
        idx_next   = p_rdata;
        state_next = ST_REM;
      end

      ST_REM: begin
        // removal of slot idx: the last entry moves in, then sifts
        qvalid_next[gone] = 1'b0;
        if (idx == IDX_W'(count - 1'b1)) begin
          count_next = count - 1'b1;
          state_next = ST_FIN;
        end else begin
          h_raddr    = IDX_W'(count - 1'b1);
          state_next = ST_REM_LD;
        end
      end

      ST_REM_LD: begin
        cur_next   = h_rdata;
        count_next = count - 1'b1;
        downf_next = 1'b1;
        state_next = ST_UP_A;
      end

      ST_UP_A: begin
        if (idx == '0) begin
          if (downf) begin
            state_next = ST_DN_L;
          end else begin
            hw_en      = 1'b1;
            pw_en      = 1'b1;
            state_next = ST_FIN;
          end
        end else begin
          h_raddr    = pidx;
          state_next = ST_UP_B;
        end
      end

      ST_UP_B: begin
        if (cur.exp < h_rdata.exp) begin
          // parent moves down into the hole
          hw_en      = 1'b1;
          hw_data    = h_rdata;
          pw_en      = 1'b1;
          pw_addr    = h_rdata.id;
          idx_next   = pidx;
          downf_next = 1'b0;
          state_next = ST_UP_A;
        end else if (downf) begin
          state_next = ST_DN_L;
        end else begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = ST_FIN;
        end
      end

      ST_DN_L: begin
        if (lidx >= cnt_x) begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = ST_FIN;
        end else begin
          h_raddr    = IDX_W'(lidx);
          state_next = ST_DN_LW;
        end
      end

      ST_DN_LW: begin
        lchild_next = h_rdata;
        h_raddr     = IDX_W'(ridx);
        state_next  = ST_DN_R;
      end

      ST_DN_R: begin
        if (take_r) begin
          hw_en      = 1'b1;
          hw_data    = h_rdata;
          pw_en      = 1'b1;
          pw_addr    = h_rdata.id;
          idx_next   = IDX_W'(ridx);
          state_next = ST_DN_L;
        end else if (take_l) begin
          hw_en      = 1'b1;
          hw_data    = lchild;
          pw_en      = 1'b1;
          pw_addr    = lchild.id;
          idx_next   = IDX_W'(lidx);
          state_next = ST_DN_L;
        end else begin
          hw_en      = 1'b1;
          pw_en      = 1'b1;
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        if (op == CMD_POP) begin
          state_next = ST_POP_RD;
        end else if (slot_free) begin
          emit                   = 1'b1;
          emit_data.kind         = KIND_ACK;
          emit_data.status       = status;
          emit_data.queued_count = 7'(count);
          emit_data.last         = 1'b1;
          state_next             = ST_IDLE;
        end
      end

      ST_POP_RD: begin
        state_next = ST_POP_CHK;
      end

      ST_POP_CHK: begin
        // held-back id goes out once it is known whether another follows
        if ((count != '0) && (h_rdata.exp <= now_r)) begin
          if (!pend_v || slot_free) begin
            if (pend_v) begin
              emit                   = 1'b1;
              emit_data.kind         = KIND_EXPIRED;
              emit_data.expired_id   = pend_id;
              emit_data.queued_count = 7'(count);
            end
            pend_v_next  = 1'b1;
            pend_id_next = h_rdata.id;
            gone_next    = h_rdata.id;
            idx_next     = '0;
            state_next   = ST_REM;
          end
        end else if (slot_free) begin
          emit                   = 1'b1;
          emit_data.kind         = pend_v ? KIND_EXPIRED : KIND_NONE;
          emit_data.expired_id   = pend_v ? pend_id : '0;
          emit_data.queued_count = 7'(count);
          emit_data.last         = 1'b1;
          pend_v_next            = 1'b0;
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
